FILE: src/cdt_pkg.sv
`timescale 1ns / 1ps

package cdt_pkg;

  // Operation codes of a command word
  typedef logic [1:0] op_t;
  localparam op_t OP_TICK   = 2'd0;
  localparam op_t OP_DIGIT  = 2'd1;
  localparam op_t OP_BACK   = 2'd2;
  localparam op_t OP_TOGGLE = 2'd3;

  // Register indexes on the configuration port
  localparam int CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_TICKS_PER_SECOND = 1'd0;
  localparam cfg_index_t REG_ALARM_HOLD_TICKS = 1'd1;

  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_DATA_W-1:0] TICKS_PER_SECOND_RESET = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] ALARM_HOLD_TICKS_RESET = 16'd1000;

  // Field widths
  localparam int DIGIT_W  = 4;
  localparam int VALUE_W  = 10;
  localparam int COUNT_W  = 2;
  localparam int TICK_W   = 16;

  // Entry limits
  localparam int MAX_ENTRY_DIGITS = 3;
  localparam int DIGIT_CNT_W      = $clog2(MAX_ENTRY_DIGITS + 1);
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // value * 10 + digit fits in this many bits
  localparam int PROD_W = VALUE_W + 4;

  // x / 10 == (x * 205) >> 11 for every 10-bit x
  localparam int DIV10_MUL_W = 8;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 8'd205;
  localparam int DIV10_SHIFT = 11;

  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [TICK_W-1:0]      tick_t;
  typedef logic [DIGIT_CNT_W-1:0] digit_cnt_t;

endpackage

FILE: src/cdt_if.sv
`timescale 1ns / 1ps

// Command channel: one keypad or tick word
interface cdt_cmd_if;
  logic           valid;
  logic           ready;
  cdt_pkg::op_t   operation;
  cdt_pkg::digit_t digit_value;

  modport source (output valid, output operation, output digit_value, input ready);
  modport sink   (input valid, input operation, input digit_value, output ready);
endinterface

// Status channel: one display word per command
interface cdt_stat_if;
  logic            valid;
  logic            ready;
  cdt_pkg::value_t shown_seconds;
  cdt_pkg::count_t entered_digit_count;
  logic            is_running;
  logic            times_up;

  modport source (output valid, output shown_seconds, output entered_digit_count,
                  output is_running, output times_up, input ready);
  modport sink   (input valid, input shown_seconds, input entered_digit_count,
                  input is_running, input times_up, output ready);
endinterface

FILE: src/countdown_timer_digit_entry_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// cmd       in   valid/ready    operation, digit_value
// status    out  valid/ready    shown_seconds, entered_digit_count, is_running, times_up
// cfg       in   cfg_we only    cfg_index, cfg_data (0 ticks/second, 1 alarm hold ticks)
//
// Two register stages: command register, then status register; one word per cycle while status is not stalled.
// An accepted command passes through the command register, then the status register, to status valid.
// Timer state updates as a word moves from the command register into the status register.
// A stalled status word holds the pipe; cmd.ready stays high while any stage is free.
// Synchronous reset clears timer state and loads both config registers with 1000.

module countdown_timer_digit_entry_top (
  input  logic                         clk,
  input  logic                         rst,
  cdt_cmd_if.sink                      cmd,
  cdt_stat_if.source                   status,
  input  logic                         cfg_we,
  input  cdt_pkg::cfg_index_t          cfg_index,
  input  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  cdt_pkg::tick_t ticks_per_second;
  cdt_pkg::tick_t alarm_hold_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= cdt_pkg::TICKS_PER_SECOND_RESET;
      alarm_hold_ticks <= cdt_pkg::ALARM_HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cdt_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        cdt_pkg::REG_ALARM_HOLD_TICKS: alarm_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command register
  logic            in_valid;
  cdt_pkg::op_t    op_q;
  cdt_pkg::digit_t dig_q;
  logic            out_valid;
  logic            advance;

  assign advance   = in_valid && (!out_valid || status.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q  <= cmd.operation;
      dig_q <= cmd.digit_value;
    end
  end

  // Timer state
  cdt_pkg::value_t     entered_value, entered_value_next;
  cdt_pkg::digit_cnt_t digit_counter, digit_counter_next;
  logic                running_flag, running_flag_next;
  cdt_pkg::value_t     remaining_seconds, remaining_seconds_next;
  cdt_pkg::tick_t      subsecond_ticks, subsecond_ticks_next;
  logic                alarm_flag, alarm_flag_next;
  cdt_pkg::tick_t      alarm_ticks, alarm_ticks_next;

  // Digit append, backspace and tick increment datapath
  logic [cdt_pkg::PROD_W-1:0] append_sum;
  logic [cdt_pkg::VALUE_W+cdt_pkg::DIV10_MUL_W-1:0] div_prod;
  cdt_pkg::value_t            value_div10;
  cdt_pkg::tick_t             sub_inc;
  cdt_pkg::tick_t             alarm_inc;

  always_comb begin
    append_sum = ({4'd0, entered_value} << 3) + ({4'd0, entered_value} << 1)
               + cdt_pkg::PROD_W'(dig_q);
    div_prod    = (cdt_pkg::VALUE_W + cdt_pkg::DIV10_MUL_W)'(entered_value)
                * (cdt_pkg::VALUE_W + cdt_pkg::DIV10_MUL_W)'(cdt_pkg::DIV10_MUL);
    value_div10 = cdt_pkg::VALUE_W'(div_prod >> cdt_pkg::DIV10_SHIFT);
    sub_inc     = subsecond_ticks + 16'd1;
    alarm_inc   = alarm_ticks + 16'd1;
  end

  // Next state for the word in the command register
  always_comb begin
    entered_value_next     = entered_value;
    digit_counter_next     = digit_counter;
    running_flag_next      = running_flag;
    remaining_seconds_next = remaining_seconds;
    subsecond_ticks_next   = subsecond_ticks;
    alarm_flag_next        = alarm_flag;
    alarm_ticks_next       = alarm_ticks;
    case (op_q)
      cdt_pkg::OP_TICK: begin
        if (running_flag) begin
          subsecond_ticks_next = sub_inc;
          if (sub_inc >= ticks_per_second) begin
            subsecond_ticks_next = '0;
            if (remaining_seconds == '0) begin
              running_flag_next = 1'b0;
              alarm_flag_next   = 1'b1;
              alarm_ticks_next  = '0;
            end else begin
              remaining_seconds_next = remaining_seconds - 10'd1;
            end
          end
        end else if (alarm_flag) begin
          alarm_ticks_next = alarm_inc;
          if (alarm_inc >= alarm_hold_ticks) begin
            alarm_flag_next = 1'b0;
          end
        end
      end
      cdt_pkg::OP_DIGIT: begin
        if (!running_flag && dig_q <= cdt_pkg::DIGIT_MAX &&
            digit_counter < cdt_pkg::DIGIT_CNT_W'(cdt_pkg::MAX_ENTRY_DIGITS)) begin
          // saturate entries that overflow ten bits
          if (append_sum > cdt_pkg::PROD_W'(cdt_pkg::VALUE_MAX)) begin
            entered_value_next = cdt_pkg::VALUE_MAX;
          end else begin
            entered_value_next = append_sum[cdt_pkg::VALUE_W-1:0];
          end
          digit_counter_next = digit_counter + cdt_pkg::digit_cnt_t'(1);
        end
      end
      cdt_pkg::OP_BACK: begin
        if (!running_flag && digit_counter != '0) begin
          entered_value_next = value_div10;
          digit_counter_next = digit_counter - cdt_pkg::digit_cnt_t'(1);
        end
      end
      cdt_pkg::OP_TOGGLE: begin
        if (running_flag) begin
          running_flag_next = 1'b0;
        end else begin
          running_flag_next      = 1'b1;
          remaining_seconds_next = entered_value;
          subsecond_ticks_next   = '0;
          alarm_flag_next        = 1'b0;
          alarm_ticks_next       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entered_value     <= '0;
      digit_counter     <= '0;
      running_flag      <= 1'b0;
      remaining_seconds <= '0;
      subsecond_ticks   <= '0;
      alarm_flag        <= 1'b0;
      alarm_ticks       <= '0;
    end else if (advance) begin
      entered_value     <= entered_value_next;
      digit_counter     <= digit_counter_next;
      running_flag      <= running_flag_next;
      remaining_seconds <= remaining_seconds_next;
      subsecond_ticks   <= subsecond_ticks_next;
      alarm_flag        <= alarm_flag_next;
      alarm_ticks       <= alarm_ticks_next;
    end
  end

  // Status register
  logic [cdt_pkg::DIGIT_CNT_W+1:0] cnt_ext;
  cdt_pkg::count_t                 count_shown;

  always_comb begin
    cnt_ext = (cdt_pkg::DIGIT_CNT_W + 2)'(digit_counter_next);
    if (cnt_ext > (cdt_pkg::DIGIT_CNT_W + 2)'(3)) begin
      count_shown = 2'd3;
    end else begin
      count_shown = cnt_ext[cdt_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status.shown_seconds       <= running_flag_next ? remaining_seconds_next
                                                      : entered_value_next;
      status.entered_digit_count <= count_shown;
      status.is_running          <= running_flag_next;
      status.times_up            <= alarm_flag_next;
    end
  end

  assign status.valid = out_valid;

  // Checks
  a_run_alarm_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(running_flag && alarm_flag))
    else $error("timer running with time's-up raised");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    digit_counter <= cdt_pkg::DIGIT_CNT_W'(cdt_pkg::MAX_ENTRY_DIGITS))
    else $error("digit count beyond entry limit");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    digit_counter == '0 |-> entered_value == '0)
    else $error("empty entry holds a nonzero value");

  a_entry_frozen: assert property (@(posedge clk) disable iff (rst)
    running_flag |=> entered_value == $past(entered_value))
    else $error("entered value changed while running");

endmodule

FILE: dv/countdown_timer_digit_entry_top_tb.sv
`timescale 1ns / 1ps

module countdown_timer_digit_entry_top_tb;
  import cdt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    op_t    op;
    digit_t digit;
  } key_word_t;

  typedef struct packed {
    value_t secs;
    count_t digits;
    logic   running;
    logic   alarm;
  } timer_status_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cdt_cmd_if  cmd_ch ();
  cdt_stat_if stat_ch ();

  countdown_timer_digit_entry_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .status    (stat_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Timer model state
  value_t     entry_value;
  digit_cnt_t entry_digits;
  logic       counting;
  value_t     secs_left;
  tick_t      sub_ticks;
  logic       alarm_up;
  tick_t      alarm_cnt;
  tick_t      sec_ticks;
  tick_t      hold_ticks;

  key_word_t     pending_cmds[$];
  timer_status_t expected_status[$];
  int            n_queued;
  int            n_accepted;
  int            n_errors;
  int            cycle_count;

  // Sender burst / gap state, receiver stall state
  int burst_left;
  int gap_left;
  int stall_pct;
  int stall_span;

  key_word_t     next_word;
  timer_status_t exp_s;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Known values on every input from time zero
  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.operation   = OP_TICK;
    cmd_ch.digit_value = '0;
    stat_ch.ready      = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_TICKS_PER_SECOND;
    cfg_data           = '0;
  end

  // Apply one accepted key word to the model, queue the status it yields
  task automatic advance_timer(input op_t op, input digit_t d);
    int v;
    timer_status_t s;
    case (op)
      OP_TICK: begin
        if (counting) begin
          sub_ticks = sub_ticks + tick_t'(1);
          if (sub_ticks >= sec_ticks) begin
            sub_ticks = '0;
            if (secs_left == '0) begin
              counting  = 1'b0;
              alarm_up  = 1'b1;
              alarm_cnt = '0;
            end else begin
              secs_left = secs_left - value_t'(1);
            end
          end
        end else if (alarm_up) begin
          alarm_cnt = alarm_cnt + tick_t'(1);
          if (alarm_cnt >= hold_ticks) alarm_up = 1'b0;
        end
      end
      OP_DIGIT: begin
        if (!counting && d <= DIGIT_MAX && entry_digits < MAX_ENTRY_DIGITS) begin
          v = int'(entry_value) * 10 + int'(d);
          entry_value  = (v > int'(VALUE_MAX)) ? VALUE_MAX : value_t'(v);
          entry_digits = entry_digits + digit_cnt_t'(1);
        end
      end
      OP_BACK: begin
        if (!counting && entry_digits > 0) begin
          entry_value  = value_t'(entry_value / 10);
          entry_digits = entry_digits - digit_cnt_t'(1);
        end
      end
      default: begin
        if (counting) begin
          counting = 1'b0;
        end else begin
          counting  = 1'b1;
          secs_left = entry_value;
          sub_ticks = '0;
          alarm_up  = 1'b0;
          alarm_cnt = '0;
        end
      end
    endcase
    s.secs    = counting ? secs_left : entry_value;
    s.digits  = (entry_digits > 3) ? count_t'(3) : count_t'(entry_digits);
    s.running = counting;
    s.alarm   = alarm_up;
    expected_status.push_back(s);
  endtask

  task automatic push_key(input op_t op, input digit_t d);
    key_word_t w;
    w.op    = op;
    w.digit = d;
    pending_cmds.push_back(w);
    n_queued++;
  endtask

  // Config writes; only issued while nothing is in flight
  task automatic set_timing(input tick_t tps, input tick_t hold);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICKS_PER_SECOND;
    cfg_data  <= tps;
    sec_ticks = tps;
    @(posedge clk);
    cfg_index <= REG_ALARM_HOLD_TICKS;
    cfg_data  <= hold;
    hold_ticks = hold;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Clear entry, key a short value, start, then tick toward expiry and hold (at most 80 ticks) or cancel early
  task automatic queue_countdown(input int tps, input int hold);
    int n;
    int val;
    int ticks;
    int d;
    repeat (3) push_key(OP_BACK, digit_t'($urandom_range(0, 15)));
    n   = $urandom_range(1, 3);
    val = 0;
    repeat (n) begin
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
      push_key(OP_DIGIT, digit_t'(d));
      if (d <= 9) val = val * 10 + d;
    end
    if ($urandom_range(0, 3) == 0) push_key(OP_DIGIT, digit_t'($urandom_range(0, 15)));
    // trim long entries so countdowns stay short
    while (val > 12) begin
      push_key(OP_BACK, digit_t'($urandom_range(0, 15)));
      val = val / 10;
    end
    push_key(OP_TOGGLE, digit_t'($urandom_range(0, 15)));
    if ($urandom_range(0, 4) == 0)
      push_key(op_t'($urandom_range(1, 2)), digit_t'($urandom_range(0, 15)));
    ticks = (val + 1) * ((tps == 0) ? 1 : tps) + ((hold == 0) ? 1 : hold)
            + $urandom_range(0, 3);
    if (ticks > 80) ticks = 80;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(0, ticks)) push_key(OP_TICK, digit_t'($urandom_range(0, 15)));
      push_key(OP_TOGGLE, digit_t'($urandom_range(0, 15)));
    end else begin
      repeat (ticks) push_key(OP_TICK, digit_t'($urandom_range(0, 15)));
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 8))
      push_key(op_t'($urandom_range(0, 3)), digit_t'($urandom_range(0, 15)));
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_word = pending_cmds.pop_front();
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= next_word.op;
        cmd_ch.digit_value <= next_word.digit;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall rate is redrawn from 0, 25, 60 or 90 percent after each random span
  always @(posedge clk) begin
    if (rst) begin
      stat_ch.ready <= 1'b1;
      stall_pct  = 0;
      stall_span = 0;
    end else begin
      if (stall_span == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        stall_span = $urandom_range(16, 200);
      end else begin
        stall_span--;
      end
      stat_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Predict on each accepted key word, check each accepted status word
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        advance_timer(cmd_ch.operation, cmd_ch.digit_value);
        n_accepted++;
      end
      if (stat_ch.valid && stat_ch.ready) begin
        if (expected_status.size() == 0) begin
          $error("status word with no expectation pending");
          n_errors++;
        end else begin
          exp_s = expected_status.pop_front();
          if (stat_ch.shown_seconds !== exp_s.secs) begin
            $error("shown_seconds: expected %0d, got %0d", exp_s.secs, stat_ch.shown_seconds);
            n_errors++;
          end
          if (stat_ch.entered_digit_count !== exp_s.digits) begin
            $error("entered_digit_count: expected %0d, got %0d",
                   exp_s.digits, stat_ch.entered_digit_count);
            n_errors++;
          end
          if (stat_ch.is_running !== exp_s.running) begin
            $error("is_running: expected %0b, got %0b", exp_s.running, stat_ch.is_running);
            n_errors++;
          end
          if (stat_ch.times_up !== exp_s.alarm) begin
            $error("times_up: expected %0b, got %0b", exp_s.alarm, stat_ch.times_up);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int phase_tps[9]  = '{1, 0, 3, 65535, 2, 1, -1, -1, 4};
    int phase_hold[9] = '{1, 0, 5, 65535, 4, 65535, -1, -1, 1};
    int phase_len[9]  = '{90, 80, 90, 40, 90, 40, 100, 100, 60};
    int tps;
    int hold;
    int target;

    // model reset state
    entry_value  = '0;
    entry_digits = '0;
    counting     = 1'b0;
    secs_left    = '0;
    sub_ticks    = '0;
    alarm_up     = 1'b0;
    alarm_cnt    = '0;
    sec_ticks    = TICKS_PER_SECOND_RESET;
    hold_ticks   = ALARM_HOLD_TICKS_RESET;
    n_queued     = 0;
    n_accepted   = 0;
    n_errors     = 0;
    cycle_count  = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Entry edge cases under reset timing: full entry, digits above nine,
    // backspace on empty, keys ignored while running, cancel keeps entry
    repeat (3) push_key(OP_DIGIT, digit_t'(9));
    push_key(OP_DIGIT, digit_t'(5));
    push_key(OP_BACK, '0);
    push_key(OP_BACK, '0);
    push_key(OP_DIGIT, digit_t'(12));
    push_key(OP_DIGIT, digit_t'(15));
    push_key(OP_BACK, '0);
    push_key(OP_BACK, '0);
    push_key(OP_DIGIT, digit_t'(0));
    push_key(OP_DIGIT, digit_t'(7));
    push_key(OP_TOGGLE, '0);
    push_key(OP_DIGIT, digit_t'(3));
    push_key(OP_BACK, '0);
    push_key(OP_TICK, '0);
    push_key(OP_TOGGLE, '0);
    wait_idle();

    // Expiry, restart while time's-up is shown, hold period running out
    set_timing(16'd1, 16'd2);
    push_key(OP_BACK, '0);
    push_key(OP_BACK, '0);
    push_key(OP_DIGIT, digit_t'(1));
    push_key(OP_TOGGLE, '0);
    repeat (2) push_key(OP_TICK, '0);
    push_key(OP_TOGGLE, '0);
    repeat (4) push_key(OP_TICK, '0);
    wait_idle();

    // Random phases, each under its own timing setting
    for (int p = 0; p < 9; p++) begin
      tps  = (phase_tps[p] < 0) ? $urandom_range(1, 4) : phase_tps[p];
      hold = (phase_hold[p] < 0) ? $urandom_range(1, 8) : phase_hold[p];
      set_timing(tick_t'(tps), tick_t'(hold));
      target = n_queued + phase_len[p];
      while (n_queued < target) begin
        if ($urandom_range(0, 4) == 0) queue_noise();
        else queue_countdown(tps, hold);
      end
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
